>>> hdl/gppc_pkg.sv
// Shared types and constants for the gas concentration converter.
// Used by the front end, back end, top level and checker; depends on nothing.
`timescale 1ns / 1ps

package gppc_pkg;

    localparam int ADC_WIDTH_DEF = 12;
    localparam int FRAC_BITS_DEF = 16;

    // Register indexes on the configuration port (byte address 4 * index).
    localparam logic [1:0] REG_REFERENCE  = 2'd0;
    localparam logic [1:0] REG_CAL_VALID  = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE = 2'd2;

    localparam logic [15:0] PPM_MAX  = 16'hFFFF;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [29:0] COEF_Q32 = 30'd550614807;
    localparam int          TAYLOR_TERMS = 16;

    // One classified sample: the four log2 operands and the bypass flags.
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic        bypass;
        logic        fault;
    } item_t;

    typedef struct packed {
        logic bypass;
        logic fault;
    } ctl_t;

    // Working set of the exp2 series.
    typedef struct packed {
        logic        neg;
        logic        big;
        logic [4:0]  sh;
        logic [31:0] x;
        logic [31:0] term;
        logic [33:0] sum;
    } tl_t;

    typedef struct packed {
        logic [15:0] ppm;
        logic        fault;
    } out_t;

endpackage

>>> hdl/gppc_fifo.sv
// Two-entry queue with push/full and pop/empty sides.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps

module gppc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hdl/gppc_front.sv
// Front end: configuration registers, APB-style port and sample classification.
// Depends on gppc_pkg.
`timescale 1ns / 1ps

module gppc_front #(
    parameter int ADC_WIDTH = gppc_pkg::ADC_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic [11:0]         measurement,
    input  logic                q_full,
    output logic                q_push,
    output gppc_pkg::item_t     q_item
);
    import gppc_pkg::*;

    localparam int          MASK_BITS = (ADC_WIDTH < 12) ? ADC_WIDTH : 12;
    localparam logic [11:0] ADC_MASK  = 12'((13'd1 << MASK_BITS) - 13'd1);
    localparam logic [15:0] FS_RESET  = 16'(17'd1 << ADC_WIDTH);

    logic [11:0] ref_reg;
    logic [11:0] ref_next;
    logic        cal_reg;
    logic        cal_next;
    logic [15:0] fs_reg;
    logic [15:0] fs_next;
    logic        wr;
    logic [15:0] m16;
    logic [15:0] r16;
    logic        flt;
    logic        byp;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        ref_next = ref_reg;
        cal_next = cal_reg;
        fs_next  = fs_reg;
        if (wr)
        begin
            case (paddr[3:2])
                REG_REFERENCE:  ref_next = pwdata[11:0];
                REG_CAL_VALID:  cal_next = pwdata[0];
                REG_FULL_SCALE: fs_next  = pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= 12'd0;
            cal_reg <= 1'b0;
            fs_reg  <= FS_RESET;
        end
        else
        begin
            ref_reg <= ref_next;
            cal_reg <= cal_next;
            fs_reg  <= fs_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_REFERENCE:  prdata = {20'd0, ref_reg};
            REG_CAL_VALID:  prdata = {31'd0, cal_reg};
            REG_FULL_SCALE: prdata = {16'd0, fs_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // A sample that cannot be converted skips the arithmetic; the back end
    // still carries it so results leave in order.
    assign m16 = {4'd0, measurement & ADC_MASK};
    assign r16 = {4'd0, ref_reg & ADC_MASK};
    assign flt = (m16 == 16'd0) || !cal_reg || (r16 >= fs_reg) || (m16 >= fs_reg);
    assign byp = flt || (r16 == 16'd0);

    always_comb
    begin
        q_item.bypass = byp;
        q_item.fault  = flt;
        q_item.a      = byp ? 16'd1 : fs_reg - m16;
        q_item.b      = byp ? 16'd1 : r16;
        q_item.c      = byp ? 16'd1 : m16;
        q_item.d      = byp ? 16'd1 : fs_reg - r16;
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

>>> hdl/gppc_log2.sv
// Pipelined log2 of a 16-bit integer: normalize, then one squaring per stage.
// Result in Q.FRAC_BITS, truncated. Depends on nothing.
`timescale 1ns / 1ps

module gppc_log2 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [15:0]            x,
    output logic [FRAC_BITS+3:0]   r
);

    localparam int RW = FRAC_BITS + 4;

    logic [31:0]   y_reg [0:FRAC_BITS];
    logic [RW-1:0] r_reg [0:FRAC_BITS];
    logic [3:0]    n;
    logic [31:0]   y_norm;

    always_comb
    begin
        n = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (x[i])
            begin
                n = 4'(i);
            end
        end
        y_norm = {16'd0, x} << (5'd31 - {1'b0, n});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0] <= y_norm;
            r_reg[0] <= RW'(n);
        end
    end

    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] y2;

        assign sq = 64'(y_reg[i]) * 64'(y_reg[i]);
        assign y2 = sq[63:31];

        // The square lies in [1, 4); a value of 2 or more gives a one bit
        // and is halved back into [1, 2).
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_reg[i+1] <= y2[32] ? y2[32:1] : y2[31:0];
                r_reg[i+1] <= {r_reg[i][RW-2:0], y2[32]};
            end
        end
    end

    assign r = r_reg[FRAC_BITS];

endmodule

>>> hdl/gppc_back.sv
// Back end: log2 terms, exponent scaling, exp2 series, coefficient and rounding.
// Depends on gppc_pkg and gppc_log2.
`timescale 1ns / 1ps

module gppc_back #(
    parameter int FRAC_BITS = gppc_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  gppc_pkg::item_t    q_item,
    output logic               q_pop,
    input  logic               o_full,
    output logic               o_push,
    output gppc_pkg::out_t     o_data
);
    import gppc_pkg::*;

    localparam int RW     = FRAC_BITS + 4;
    localparam int LGW    = FRAC_BITS + 7;
    localparam int ABSW   = LGW - 1;
    localparam int EXW    = FRAC_BITS + 3;
    localparam int MAGW   = ABSW + EXW;
    localparam int NTL    = 2 * (TAYLOR_TERMS - 1) + 1;
    localparam int NST    = FRAC_BITS + 4 + NTL;
    localparam logic [EXW-1:0] EXPO_FIX =
        EXW'((64'd3833 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    logic                adv;
    logic [NST-1:0]      valid_reg;
    ctl_t                ctl_reg [0:NST-1];
    logic [RW-1:0]       ra;
    logic [RW-1:0]       rb;
    logic [RW-1:0]       rc;
    logic [RW-1:0]       rd;
    logic signed [LGW-1:0] lg_s;
    logic signed [LGW-1:0] lg_a;
    logic                neg_a_reg;
    logic [ABSW-1:0]     abs_reg;
    logic                neg_b_reg;
    logic [MAGW-1:0]     mag_reg;
    logic [63:0]         x32;
    logic [63:0]         xprod;
    tl_t                 tl_first;
    tl_t                 tl_reg [0:NTL-1];
    logic [63:0]         pprod;
    logic [31:0]         p_reg;
    logic                pneg_reg;
    logic                pbig_reg;
    logic [4:0]          psh_reg;
    logic [63:0]         shifted;
    logic [63:0]         rounded;
    ctl_t                ctl_out;

    // The whole pipe moves together and holds while the result queue is full.
    assign adv   = !o_full;
    assign q_pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NST-2:0], !q_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= '{bypass: q_item.bypass, fault: q_item.fault};
            for (int i = 1; i < NST; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    gppc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_a (.clk(clk), .en(adv), .x(q_item.a), .r(ra));
    gppc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_b (.clk(clk), .en(adv), .x(q_item.b), .r(rb));
    gppc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_c (.clk(clk), .en(adv), .x(q_item.c), .r(rc));
    gppc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_d (.clk(clk), .en(adv), .x(q_item.d), .r(rd));

    // log2 of the resistance ratio, split into sign and magnitude.
    assign lg_s = $signed(LGW'(ra)) + $signed(LGW'(rb))
                - $signed(LGW'(rc)) - $signed(LGW'(rd));
    assign lg_a = lg_s[LGW-1] ? -lg_s : lg_s;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_a_reg <= lg_s[LGW-1];
            abs_reg   <= lg_a[ABSW-1:0];
            neg_b_reg <= neg_a_reg;
            mag_reg   <= MAGW'(abs_reg) * MAGW'(EXPO_FIX);
        end
    end

    if (2 * FRAC_BITS >= 32)
    begin : g_down
        assign x32 = 64'(mag_reg >> (2 * FRAC_BITS - 32));
    end
    else
    begin : g_up
        assign x32 = 64'(mag_reg) << (32 - 2 * FRAC_BITS);
    end

    // Only a negative log gives a nonzero result; then the exponent is
    // positive with integer part x32[63:32] and fraction x32[31:0].
    assign xprod = 64'(x32[31:0]) * 64'(LN2_Q32);

    always_comb
    begin
        tl_first.neg  = neg_b_reg;
        tl_first.big  = |x32[63:37];
        tl_first.sh   = x32[36:32];
        tl_first.x    = xprod[63:32];
        tl_first.term = xprod[63:32];
        tl_first.sum  = 34'h1_0000_0000 + 34'(xprod[63:32]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tl_reg[0] <= tl_first;
        end
    end

    for (genvar j = 0; j < TAYLOR_TERMS - 1; j++)
    begin : g_term
        localparam int          N    = j + 2;
        localparam int          L    = $clog2(N);
        localparam logic [63:0] DIVM = (64'd1 << (32 + L)) / 64'(N) + 64'd1;

        logic [63:0] mprod;
        logic [64:0] dprod;
        logic [31:0] tq;
        tl_t         mul_next;
        tl_t         div_next;

        assign mprod = 64'(tl_reg[2*j].term) * 64'(tl_reg[2*j].x);
        // Division by the term index as a reciprocal multiply, exact for
        // any 32-bit dividend.
        assign dprod = 65'(tl_reg[2*j+1].term) * 65'(DIVM[32:0]);
        assign tq    = 32'(dprod >> (32 + L));

        always_comb
        begin
            mul_next      = tl_reg[2*j];
            mul_next.term = mprod[63:32];
            div_next      = tl_reg[2*j+1];
            div_next.term = tq;
            div_next.sum  = tl_reg[2*j+1].sum + 34'(tq);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tl_reg[2*j+1] <= mul_next;
                tl_reg[2*j+2] <= div_next;
            end
        end
    end

    assign pprod = 64'(tl_reg[NTL-1].sum) * 64'(COEF_Q32);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= pprod[63:32];
            pneg_reg <= tl_reg[NTL-1].neg;
            pbig_reg <= tl_reg[NTL-1].big;
            psh_reg  <= tl_reg[NTL-1].sh;
        end
    end

    assign ctl_out = ctl_reg[NST-1];
    assign shifted = {32'd0, p_reg} << psh_reg;
    assign rounded = (shifted + 64'h8000_0000) >> 32;

    always_comb
    begin
        o_data.fault = ctl_out.fault;
        if (ctl_out.bypass || (pneg_reg && pbig_reg))
        begin
            o_data.ppm = PPM_MAX;
        end
        else if (!pneg_reg)
        begin
            o_data.ppm = 16'd0;
        end
        else if (|rounded[63:16])
        begin
            o_data.ppm = PPM_MAX;
        end
        else
        begin
            o_data.ppm = rounded[15:0];
        end
    end

    assign o_push = adv && valid_reg[NST-1];

endmodule

>>> hdl/gas_ppm_power_law_convert.sv
// Top level of the gas concentration converter.
// Depends on gppc_pkg, gppc_front, gppc_fifo and gppc_back.
`timescale 1ns / 1ps

// Converts one ADC sample of a metal-oxide gas sensor divider into ppm using
// ppm = 0.1282 * (Rs/R0)^-3.833 in fixed point, saturating at 65535; fault is
// set for a zero sample, a sample or reference at or above full scale, or an
// invalid calibration. One sample is taken per clock cycle while the input
// queue is not full. Pipeline length comes from the log2 units, which square
// once per stage, and the fifteen exp2 series terms, each a multiply stage and
// a divide stage. Configuration is to be written by the user over the APB-style
// port only while no beat is in flight; the block does not enforce this.
module gas_ppm_power_law_convert #(
    parameter int ADC_WIDTH = gppc_pkg::ADC_WIDTH_DEF,
    parameter int FRAC_BITS = gppc_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [11:0] measurement,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] ppm,
    output logic        fault
);
    import gppc_pkg::*;

    item_t item_in;
    item_t item_out;
    logic  mq_push;
    logic  mq_full;
    logic  mq_empty;
    logic  mq_pop;
    out_t  res_in;
    out_t  res_out;
    logic  rq_push;
    logic  rq_full;

    gppc_front #(.ADC_WIDTH(ADC_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .measurement (measurement),
        .q_full      (mq_full),
        .q_push      (mq_push),
        .q_item      (item_in)
    );

    gppc_fifo #(.WIDTH($bits(item_t))) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .din   (item_in),
        .pop   (mq_pop),
        .dout  (item_out),
        .full  (mq_full),
        .empty (mq_empty)
    );

    gppc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mq_empty),
        .q_item  (item_out),
        .q_pop   (mq_pop),
        .o_full  (rq_full),
        .o_push  (rq_push),
        .o_data  (res_in)
    );

    gppc_fifo #(.WIDTH($bits(out_t))) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (res_in),
        .pop   (pop),
        .dout  (res_out),
        .full  (rq_full),
        .empty (empty)
    );

    assign ppm   = res_out.ppm;
    assign fault = res_out.fault;

endmodule

>>> hdl/gppc_checker.sv
// Port-level checks for the gas concentration converter, bound to the top level.
// Depends on gppc_pkg and gas_ppm_power_law_convert.
`timescale 1ns / 1ps

module gppc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        push,
    input logic        full,
    input logic [11:0] measurement,
    input logic        empty,
    input logic        pop,
    input logic [15:0] ppm,
    input logic        fault
);
    import gppc_pkg::*;

    // A waiting result that is not taken stays.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(ppm) && $stable(fault)))
        else $error("result beat changed while stalled");

    // A faulted result always reads as saturated.
    a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && fault) |-> (ppm == PPM_MAX))
        else $error("fault beat without saturated ppm");

    // The full-scale register reads back what was last written.
    a_fs_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[3:2] == REG_FULL_SCALE))
        |=> ((paddr[3:2] != REG_FULL_SCALE) || (prdata[15:0] == $past(pwdata[15:0]))))
        else $error("full-scale register readback mismatch");

endmodule

bind gas_ppm_power_law_convert gppc_checker u_gppc_checker (.*);
